FILE: hw/rtl/afr_pkg.sv
package afr_pkg;

  // buffer geometry
  localparam int BUF_DEPTH = 256;
  localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FILL_W    = $clog2(BUF_DEPTH + 1);
  localparam int MEM_AW    = BUF_AW + 1;
  localparam int MEM_WORDS = 2 ** MEM_AW;

  // op queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // command codes on the input channel
  typedef enum logic [1:0] {
    CMD_RX   = 2'd0,
    CMD_READ = 2'd1,
    CMD_ACK  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // classified operation
  typedef enum logic [1:0] {
    OP_RX,
    OP_READ,
    OP_ACK,
    OP_NONE
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;  // received byte or read index
  } op_t;

  // receive framing phase
  typedef enum logic [2:0] {
    PH_ADDR_HI = 3'd0,
    PH_ADDR_LO = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_DATA    = 3'd4
  } rx_phase_t;

  // back end sequencer
  typedef enum logic {
    B_EXEC,
    B_READ
  } back_state_t;

endpackage

FILE: hw/rtl/afr_front.sv
module afr_front
  import afr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [7:0] rx_byte,
  input  logic [7:0] read_index,
  output logic       op_valid,
  input  logic       op_ready,
  output op_t        op
);

  logic f_valid;
  op_t  f_op;
  op_t  dec_op;

  // classify the incoming beat
  always_comb begin
    dec_op = '{kind: OP_NONE, data: 8'h00};
    unique case (cmd_t'(command))
      CMD_RX: begin
        dec_op.kind = OP_RX;
        dec_op.data = rx_byte;
      end
      CMD_READ: begin
        dec_op.kind = OP_READ;
        dec_op.data = read_index;
      end
      CMD_ACK:  dec_op.kind = OP_ACK;
      default:  dec_op.kind = OP_NONE;
    endcase
  end

  assign in_ready = !f_valid || op_ready;
  assign op_valid = f_valid;
  assign op       = f_op;

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_op <= dec_op;
    end
  end

endmodule

FILE: hw/rtl/afr_queue.sv
module afr_queue
  import afr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop,
  output op_t  pop_op
);

  op_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QUEUE_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QUEUE_AW + 1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

FILE: hw/rtl/afr_back.sv
module afr_back
  import afr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] own_address,
  input  logic        op_valid,
  output logic        op_pop,
  input  op_t         op,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_done,
  output logic        frame_accepted,
  output logic        message_ready,
  output logic [15:0] ready_length,
  output logic [7:0]  read_data,
  output logic        overflow
);

  // sequencer
  back_state_t state;
  back_state_t state_next;

  // frame state
  rx_phase_t   phase;
  rx_phase_t   phase_next;
  logic [15:0] frame_address;
  logic [15:0] frame_address_next;
  logic [15:0] frame_length;
  logic [15:0] frame_length_next;
  logic [15:0] byte_count;
  logic [15:0] byte_count_next;
  logic        active_select;
  logic        active_select_next;
  logic        ready_flag;
  logic        ready_flag_next;
  logic [15:0] kept_length;
  logic [15:0] kept_length_next;
  logic [FILL_W-1:0] fill_act;
  logic [FILL_W-1:0] fill_act_next;
  logic [FILL_W-1:0] fill_inact;
  logic [FILL_W-1:0] fill_inact_next;

  // execute results
  logic        ex_done;
  logic        ex_accepted;
  logic        ex_overflow;
  logic        ex_end;
  logic [15:0] ex_len;
  logic [15:0] bc_inc;
  logic [15:0] idx_wide;

  // buffer memory
  logic [7:0]        mem [MEM_WORDS];
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic              rd_en;
  logic [MEM_AW-1:0] mem_raddr;
  logic [7:0]        mem_q;
  logic              rd_hit;

  // handshake control
  logic slot_free;
  logic exec_fire;
  logic load_exec;
  logic load_read;

  assign slot_free = !out_valid || out_ready;
  assign bc_inc    = byte_count + 16'd1;
  assign idx_wide  = {8'h00, op.data};
  assign mem_waddr = {active_select, byte_count[BUF_AW-1:0]};
  assign mem_raddr = {~active_select, idx_wide[BUF_AW-1:0]};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_EXEC: begin
        if (op_valid && slot_free && op.kind == OP_READ) begin
          state_next = B_READ;
        end
      end
      B_READ: begin
        if (slot_free) begin
          state_next = B_EXEC;
        end
      end
      default: state_next = B_EXEC;
    endcase
  end

  // sequencer outputs
  always_comb begin
    op_pop    = 1'b0;
    exec_fire = 1'b0;
    rd_en     = 1'b0;
    load_exec = 1'b0;
    load_read = 1'b0;
    unique case (state)
      B_EXEC: begin
        if (op_valid && slot_free) begin
          op_pop = 1'b1;
          if (op.kind == OP_READ) begin
            rd_en = 1'b1;
          end else begin
            exec_fire = 1'b1;
            load_exec = 1'b1;
          end
        end
      end
      B_READ: begin
        load_read = slot_free;
      end
      default: begin
        op_pop = 1'b0;
      end
    endcase
  end

  // frame handling for one non-read op
  always_comb begin
    phase_next         = phase;
    frame_address_next = frame_address;
    frame_length_next  = frame_length;
    byte_count_next    = byte_count;
    active_select_next = active_select;
    ready_flag_next    = ready_flag;
    kept_length_next   = kept_length;
    fill_act_next      = fill_act;
    fill_inact_next    = fill_inact;
    ex_done            = 1'b0;
    ex_accepted        = 1'b0;
    ex_overflow        = 1'b0;
    ex_end             = 1'b0;
    ex_len             = frame_length;
    mem_we             = 1'b0;

    unique case (op.kind)
      OP_RX: begin
        unique case (phase)
          PH_ADDR_LO: begin
            frame_address_next = {frame_address[15:8], op.data};
            phase_next         = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            frame_length_next = {op.data, 8'h00};
            phase_next        = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            ex_len            = {frame_length[15:8], op.data};
            frame_length_next = ex_len;
            if (ex_len == 16'd0) begin
              ex_end = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            if (byte_count < 16'(BUF_DEPTH)) begin
              mem_we        = exec_fire;
              fill_act_next = fill_act + FILL_W'(1);
            end else begin
              ex_overflow = 1'b1;
            end
            byte_count_next = bc_inc;
            if (bc_inc == frame_length) begin
              ex_end = 1'b1;
            end
          end
          default: begin
            frame_address_next = {op.data, 8'h00};
            phase_next         = PH_ADDR_LO;
          end
        endcase
      end
      OP_ACK:  ready_flag_next = 1'b0;
      OP_READ: ex_len = frame_length;
      OP_NONE: ex_len = frame_length;
      default: ex_len = frame_length;
    endcase

    // end of frame: swap on a match, then zero the active buffer's fill count
    if (ex_end) begin
      ex_done         = 1'b1;
      phase_next      = PH_ADDR_HI;
      byte_count_next = 16'd0;
      if (frame_address == own_address) begin
        ex_accepted        = 1'b1;
        active_select_next = ~active_select;
        ready_flag_next    = 1'b1;
        kept_length_next   = ex_len;
        fill_inact_next    = fill_act_next;
      end
      fill_act_next = '0;
    end
  end

  // control and frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_EXEC;
      phase         <= PH_ADDR_HI;
      frame_address <= 16'd0;
      frame_length  <= 16'd0;
      byte_count    <= 16'd0;
      active_select <= 1'b0;
      ready_flag    <= 1'b0;
      kept_length   <= 16'd0;
      fill_act      <= '0;
      fill_inact    <= '0;
    end else begin
      state <= state_next;
      if (exec_fire) begin
        phase         <= phase_next;
        frame_address <= frame_address_next;
        frame_length  <= frame_length_next;
        byte_count    <= byte_count_next;
        active_select <= active_select_next;
        ready_flag    <= ready_flag_next;
        kept_length   <= kept_length_next;
        fill_act      <= fill_act_next;
        fill_inact    <= fill_inact_next;
      end
    end
  end

  // buffer memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= op.data;
    end
    if (rd_en) begin
      mem_q  <= mem[mem_raddr];
      rd_hit <= (idx_wide < {{(16 - FILL_W){1'b0}}, fill_inact});
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_exec || load_read) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_exec) begin
      frame_done     <= ex_done;
      frame_accepted <= ex_accepted;
      message_ready  <= ready_flag_next;
      ready_length   <= kept_length_next;
      read_data      <= 8'h00;
      overflow       <= ex_overflow;
    end else if (load_read) begin
      frame_done     <= 1'b0;
      frame_accepted <= 1'b0;
      message_ready  <= ready_flag;
      ready_length   <= kept_length;
      read_data      <= rd_hit ? mem_q : 8'h00;
      overflow       <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/addressed_frame_receiver.sv
// path: front holding register, op queue, then result register
// throughput: one beat per cycle while in_ready is high; a buffer read
//   holds the back end in B_READ: memory data is registered before the result
// reset: synchronous, clears framing state, swap select, ready flag and length;
//   buffer contents read as zero through per-buffer fill counts, no clear sweep
module addressed_frame_receiver
  import afr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_done,
  output logic        frame_accepted,
  output logic        message_ready,
  output logic [15:0] ready_length,
  output logic [7:0]  read_data,
  output logic        overflow
);

  logic [15:0] own_address;
  logic        f_valid;
  logic        f_ready;
  op_t         f_op;
  logic        q_valid;
  logic        q_pop;
  op_t         q_op;

  // address register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      own_address <= cfg_data;
    end
  end

  // front: accept and classify
  afr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .rx_byte    (rx_byte),
    .read_index (read_index),
    .op_valid   (f_valid),
    .op_ready   (f_ready),
    .op         (f_op)
  );

  // op queue
  afr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_op    (f_op),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_op     (q_op)
  );

  // back: framing, buffers, results
  afr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .own_address    (own_address),
    .op_valid       (q_valid),
    .op_pop         (q_pop),
    .op             (q_op),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_done     (frame_done),
    .frame_accepted (frame_accepted),
    .message_ready  (message_ready),
    .ready_length   (ready_length),
    .read_data      (read_data),
    .overflow       (overflow)
  );

  // an accepted frame is a completed frame and leaves a message waiting
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_accepted |-> frame_done && message_ready)
    else $error("frame accepted without completion or ready flag");

  // read data only comes with a read, never with receive status
  a_read_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_data != 8'h00) |-> !frame_done && !overflow)
    else $error("read data mixed with receive status");

  // nothing is pending on the first cycle out of reset
  a_reset_clear: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && !q_valid)
    else $error("result or op pending after reset");

endmodule
